// ===== rtl/tclw_pkg.sv =====
// Shared types and constants for the text console line writer.
// Depends on nothing; the queue, front, back and top-level files in rtl/ import it.
package tclw_pkg;

   // widths fixed by the item fields
   localparam int CHAR_W     = 8;
   localparam int COL_W      = 7;
   localparam int COLOR_W    = 4;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_BS      = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_DEL     = 8'd127;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;

   // blank cell, also the reset value of every cell
   localparam logic [CHAR_W-1:0]  BLANK_GLYPH = 8'd32;
   localparam logic [COLOR_W-1:0] BLANK_FORE  = 4'd0;
   localparam logic [COLOR_W-1:0] BLANK_BACK  = 4'd7;

   // register reset values and indexes
   localparam logic [COLOR_W-1:0] FG_RESET = 4'd0;
   localparam logic [COLOR_W-1:0] BG_RESET = 4'd7;
   localparam logic               REG_FG   = 1'b0;
   localparam logic               REG_BG   = 1'b1;

   // result kinds
   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_SCROLL = 1'b1;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_ERASE  = 2'd1,
      OP_SCROLL = 2'd2
   } cmd_op_type;

   typedef struct packed {
      logic [CHAR_W-1:0]  glyph;
      logic [COLOR_W-1:0] fore;
      logic [COLOR_W-1:0] back;
   } cell_type;

   localparam int CELL_W = $bits(cell_type);

   localparam cell_type BLANK_CELL = '{glyph: BLANK_GLYPH, fore: BLANK_FORE, back: BLANK_BACK};

   // one classified command from the front
   typedef struct packed {
      cmd_op_type         op;
      logic               scroll_first;
      logic [COL_W-1:0]   column;
      logic [CHAR_W-1:0]  glyph;
      logic [COLOR_W-1:0] fore;
      logic [COLOR_W-1:0] back;
   } cmd_type;

   // one result item
   typedef struct packed {
      logic             kind;
      logic [COL_W-1:0] column;
      cell_type         content;
      logic             last;
   } rsp_type;

endpackage

// ===== rtl/tclw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tclw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 80
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tclw_queue.sv =====
// Short command queue between the front and the back.
// Depends on tclw_pkg.
module tclw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  tclw_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output tclw_pkg::cmd_type pop_cmd
);
   import tclw_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/tclw_front.sv =====
// Front end: takes character transfers, tracks the cursor, classifies
// each character into a command for the back end. Depends on tclw_pkg.
module tclw_front #(
   parameter int COLUMNS = 80
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [tclw_pkg::CHAR_W-1:0]    char_code,
   input  logic [tclw_pkg::COLOR_W-1:0]   fg_color,
   input  logic [tclw_pkg::COLOR_W-1:0]   bg_color,
   output logic                           push_valid,
   input  logic                           push_ready,
   output tclw_pkg::cmd_type              push_cmd
);
   import tclw_pkg::*;

   localparam int CUR_W = $clog2(COLUMNS + 1);

   logic [CUR_W-1:0] cursor_ff, cursor_in;
   logic [CUR_W-1:0] cursor_dec;
   logic [CUR_W-1:0] write_col;
   logic             accept;
   logic             is_erase, is_newline, line_full, has_cmd;

   assign req_tready = push_ready;
   assign accept     = req_tvalid & push_ready;
   assign is_erase   = (char_code == CHAR_BS) || (char_code == CHAR_DEL);
   assign is_newline = (char_code == CHAR_NEWLINE);
   assign line_full  = (cursor_ff == CUR_W'(COLUMNS));
   assign cursor_dec = cursor_ff - CUR_W'(1);
   assign write_col  = line_full ? '0 : cursor_ff;

   always_comb begin
      cursor_in             = cursor_ff;
      has_cmd               = 1'b1;
      push_cmd.op           = OP_WRITE;
      push_cmd.scroll_first = 1'b0;
      push_cmd.column       = COL_W'(write_col);
      push_cmd.glyph        = char_code;
      push_cmd.fore         = fg_color;
      push_cmd.back         = bg_color;
      priority if (is_erase) begin
         push_cmd.op     = OP_ERASE;
         push_cmd.column = COL_W'(cursor_dec);
         // erase at column zero does nothing
         has_cmd         = (cursor_ff != '0);
         if (cursor_ff != '0) begin
            cursor_in = cursor_dec;
         end
      end else if (is_newline) begin
         push_cmd.op     = OP_SCROLL;
         push_cmd.column = '0;
         cursor_in       = '0;
      end else begin
         push_cmd.scroll_first = line_full;
         cursor_in             = write_col + CUR_W'(1);
      end
   end

   assign push_valid = accept & has_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
      end else if (accept) begin
         cursor_ff <= cursor_in;
      end
   end

endmodule

// ===== rtl/tclw_back.sv =====
// Back end: carries out commands against the line RAM and drives the
// result register. Depends on tclw_pkg and tclw_ram.
module tclw_back #(
   parameter int COLUMNS = 80
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  tclw_pkg::cmd_type pop_cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tclw_pkg::rsp_type rsp
);
   import tclw_pkg::*;

   localparam int ADDR_W = $clog2(COLUMNS);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_READ   = 3'b010,
      ST_SECOND = 3'b100
   } back_state_type;

   back_state_type     state_ff, state_in;
   logic [COLUMNS-1:0] valid_ff, valid_in;
   logic               rd_valid_ff, rd_valid_in;
   rsp_type            pend_ff, pend_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               slot_free, take;
   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   cell_type           wr_cell, rd_cell;
   rsp_type            write_rsp, scroll_rsp;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (state_ff == ST_IDLE) && slot_free;
   assign take      = pop_valid && pop_ready;
   assign wr_addr   = pop_cmd.column[ADDR_W-1:0];
   assign rd_addr   = wr_addr - ADDR_W'(1);

   assign scroll_rsp = '{kind: KIND_SCROLL, column: '0, content: BLANK_CELL, last: 1'b1};

   tclw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (COLUMNS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_cell),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_cell)
   );

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      rd_valid_in   = rd_valid_ff;
      pend_in       = pend_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      wr_cell       = '{glyph: pop_cmd.glyph, fore: pop_cmd.fore, back: pop_cmd.back};
      write_rsp     = '{kind: KIND_WRITE, column: pop_cmd.column, content: wr_cell, last: 1'b1};

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               rsp_valid_in = 1'b1;
               unique case (pop_cmd.op)
                  OP_ERASE: begin
                     wr_cell.glyph     = BLANK_GLYPH;
                     write_rsp.content = wr_cell;
                     write_rsp.last    = (wr_addr == '0);
                     wr_en             = 1'b1;
                     valid_in[wr_addr] = 1'b1;
                     rsp_in            = write_rsp;
                     if (wr_addr != '0) begin
                        // redraw the cell before the erased one
                        rd_en          = 1'b1;
                        rd_valid_in    = valid_ff[rd_addr];
                        pend_in        = write_rsp;
                        pend_in.column = COL_W'(rd_addr);
                        pend_in.last   = 1'b1;
                        state_in       = ST_READ;
                     end
                  end
                  OP_SCROLL: begin
                     valid_in = '0;
                     rsp_in   = scroll_rsp;
                  end
                  OP_WRITE: begin
                     wr_en = 1'b1;
                     if (pop_cmd.scroll_first) begin
                        valid_in          = '0;
                        valid_in[wr_addr] = 1'b1;
                        rsp_in            = scroll_rsp;
                        rsp_in.last       = 1'b0;
                        pend_in           = write_rsp;
                        state_in          = ST_SECOND;
                     end else begin
                        valid_in[wr_addr] = 1'b1;
                        rsp_in            = write_rsp;
                     end
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_ready;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_in         = pend_ff;
               rsp_in.content = rd_valid_ff ? rd_cell : BLANK_CELL;
               state_in       = ST_IDLE;
            end
         end
         ST_SECOND: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= rd_valid_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/text_console_line_writer_unit.sv =====
// Path: the first result of a character is registered in the queue on its transfer (push),
// then popped into the result register, from which it transfers to the receiver.
// Throughput: one character per cycle for printable and newline bytes while the receiver
// is ready; a backspace that redraws a cell, or a print on a full line, gives two results
// in turn, bounded by the back end's single result register and the line RAM's read port.
// Reset (synchronous, active high) homes the cursor, marks every cell blank through
// per-column valid bits, empties the queue and sets the colors to 0 and 7.
module text_console_line_writer_unit #(
   parameter int COLUMNS = 80
) (
   input  logic                               clock,
   input  logic                               reset,

   // character input
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tclw_pkg::REQ_DATA_W-1:0]    req_tdata,   // [7:0] char_code

   // result output
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tclw_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [6:0] column, [14:7] glyph,
                                                           // [18:15] fore, [22:19] back, [23] zero
   output logic                               rsp_tuser,   // [0] kind: 0 write cell, 1 scroll
   output logic                               rsp_tlast,

   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tclw_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [tclw_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [tclw_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import tclw_pkg::*;

   logic [COLOR_W-1:0] fg_color_ff, bg_color_ff;
   logic               csr_write;
   logic               csr_index;

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;
   rsp_type rsp;

   // ---- register file: fg at 0x0, bg at 0x4 ----
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_color_ff <= FG_RESET;
         bg_color_ff <= BG_RESET;
      end else if (csr_write) begin
         if (csr_index == REG_FG) begin
            fg_color_ff <= csr_pwdata[COLOR_W-1:0];
         end else begin
            bg_color_ff <= csr_pwdata[COLOR_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_index == REG_FG) ?
                       {{(CSR_DATA_W-COLOR_W){1'b0}}, fg_color_ff} :
                       {{(CSR_DATA_W-COLOR_W){1'b0}}, bg_color_ff};

   // ---- front: cursor tracking and classification ----
   tclw_front #(
      .COLUMNS (COLUMNS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .char_code  (req_tdata[CHAR_W-1:0]),
      .fg_color   (fg_color_ff),
      .bg_color   (bg_color_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // ---- command queue decouples the two halves ----
   tclw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // ---- back: line RAM and result register ----
   tclw_back #(
      .COLUMNS (COLUMNS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.content.back, rsp.content.fore, rsp.content.glyph,
                       rsp.column};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

`ifndef SYNTH
   // a scroll always reports the blank cell at column zero
   a_scroll_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_SCROLL) |->
      (rsp.column == '0 && rsp.content == BLANK_CELL))
      else $error("scroll result with non-blank payload");

   // cell writes stay on the line
   a_column_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_WRITE) |-> (rsp.column <= COL_W'(COLUMNS - 1)))
      else $error("cell write beyond the last column");

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule

// ===== tb/tb_text_console_line_writer_unit.sv =====
// Testbench for text_console_line_writer_unit: sends character bytes, predicts every cell
// write and scroll from its own copy of the bottom line, and checks each result transfer.
// Depends on rtl/tclw_pkg.sv and rtl/text_console_line_writer_unit.sv.
module tb_text_console_line_writer_unit;
   import tclw_pkg::*;

   localparam int COLUMNS     = 80;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 20;     // plenty of margin for results still on their way
   localparam int IDLE_WAIT   = 8;      // extra wait after the last expected result has arrived

   // register byte addresses: register i sits at 4*i
   localparam logic [CSR_ADDR_W-1:0] ADDR_FG = {REG_FG, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_BG = {REG_BG, 2'b00};

   // rsp_tdata field positions, lowest first
   localparam int COL_LSB   = 0;
   localparam int GLYPH_LSB = COL_LSB + COL_W;
   localparam int FORE_LSB  = GLYPH_LSB + CHAR_W;
   localparam int BACK_LSB  = FORE_LSB + COLOR_W;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;    // [7:0] char_code

   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // [6:0] column, [14:7] glyph, [18:15] fore,
                                              // [22:19] back, [23] zero
   logic                  rsp_tuser;          // [0] kind
   logic                  rsp_tlast;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   text_console_line_writer_unit #(.COLUMNS(COLUMNS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ---------------------------------------------------------------------------------
   // Console model: cursor, bottom-line cells and color registers as the unit holds them
   // ---------------------------------------------------------------------------------
   int                 cursor_col;
   cell_type           line_cells [COLUMNS];
   logic [COLOR_W-1:0] fg_reg;
   logic [COLOR_W-1:0] bg_reg;

   rsp_type            expected_cell_ops [$];   // cell writes and scrolls still to arrive

   int idle_pct;           // sender gap chance, percent
   int stall_pct;          // receiver stall chance, percent
   int errors;
   int chars_sent;
   int writes_seen;
   int scrolls_seen;
   int cycle_count;

   function automatic rsp_type cell_op(input logic kind, input int col,
                                       input cell_type content);
      rsp_type op;
      op.kind    = kind;
      op.column  = COL_W'(col);
      op.content = content;
      op.last    = 1'b0;
      return op;
   endfunction

   // Work out what one accepted character does to the line and queue the results.
   task automatic apply_char(input logic [CHAR_W-1:0] code);
      rsp_type  ops [$];
      cell_type painted;
      int       col;
      painted.fore = fg_reg;
      painted.back = bg_reg;
      if (code == CHAR_BS || code == CHAR_DEL) begin
         // nothing happens at column 0; otherwise blank the cell left of the cursor
         if (cursor_col > 0) begin
            col           = cursor_col - 1;
            cursor_col    = col;
            painted.glyph = BLANK_GLYPH;
            line_cells[col] = painted;
            ops.push_back(cell_op(KIND_WRITE, col, painted));
            // redraw the cell before it, unless the blanked cell was column 0
            if (col > 0)
               ops.push_back(cell_op(KIND_WRITE, col - 1, line_cells[col - 1]));
         end
      end else begin
         // newline, or a print on a full line, scrolls first; scrolls ignore the registers
         if (code == CHAR_NEWLINE || cursor_col >= COLUMNS) begin
            foreach (line_cells[i]) line_cells[i] = BLANK_CELL;
            ops.push_back(cell_op(KIND_SCROLL, 0, BLANK_CELL));
            cursor_col = 0;
         end
         // every other byte, control codes too, lands as a glyph
         if (code != CHAR_NEWLINE) begin
            painted.glyph = code;
            line_cells[cursor_col] = painted;
            ops.push_back(cell_op(KIND_WRITE, cursor_col, painted));
            cursor_col++;
         end
      end
      if (ops.size() > 0) ops[ops.size() - 1].last = 1'b1;
      foreach (ops[i]) expected_cell_ops.push_back(ops[i]);
   endtask

   // ---------------------------------------------------------------------------------
   // Clock, reset and run limit
   // ---------------------------------------------------------------------------------
   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Result side: random stalls, and each transfer checked against the oldest expectation
   // ---------------------------------------------------------------------------------
   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.kind          = rsp_tuser;
            seen.column        = rsp_tdata[COL_LSB +: COL_W];
            seen.content.glyph = rsp_tdata[GLYPH_LSB +: CHAR_W];
            seen.content.fore  = rsp_tdata[FORE_LSB +: COLOR_W];
            seen.content.back  = rsp_tdata[BACK_LSB +: COLOR_W];
            seen.last          = rsp_tlast;
            if (seen.kind == KIND_SCROLL) scrolls_seen++;
            else writes_seen++;
            if (expected_cell_ops.size() == 0) begin
               $error("result transfer with nothing expected: kind %0d column %0d glyph %0d",
                      seen.kind, seen.column, seen.content.glyph);
               errors++;
            end else begin
               want = expected_cell_ops.pop_front();
               check_field("kind",   want.kind,          seen.kind);
               check_field("column", want.column,        seen.column);
               check_field("glyph",  want.content.glyph, seen.content.glyph);
               check_field("fore",   want.content.fore,  seen.content.fore);
               check_field("back",   want.content.back,  seen.content.back);
               check_field("last",   want.last,          seen.last);
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------------------------
   // Sender and register access
   // ---------------------------------------------------------------------------------

   // One character transfer. Valid stays high into the next call when no gap is drawn.
   task automatic send_char(input logic [CHAR_W-1:0] code);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      do @(posedge clock); while (!req_tready);
      apply_char(code);
      chars_sent++;
   endtask

   // Drop valid and let every queued result drain before touching the registers.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_cell_ops.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   // Write one color register, then read it back.
   task automatic csr_write(input logic idx, input logic [COLOR_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= (idx == REG_FG) ? ADDR_FG : ADDR_BG;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_FG) fg_reg = value;
      else bg_reg = value;
      // back-to-back read of the same address
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback[COLOR_W-1:0] !== value) begin
         $error("register %0d readback: expected %0d, got %0d", idx, value,
                readback[COLOR_W-1:0]);
         errors++;
      end
      @(posedge clock);
   endtask

   task automatic set_colors(input logic [COLOR_W-1:0] fore, input logic [COLOR_W-1:0] back);
      wait_idle();
      csr_write(REG_FG, fore);
      csr_write(REG_BG, back);
   endtask

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Backspace and DEL at column 0 give nothing; at column 1 only the blanking write.
   task automatic test_line_start();
      send_char(CHAR_BS);
      send_char(CHAR_DEL);
      send_char(8'd65);
      send_char(CHAR_BS);
      send_char(CHAR_DEL);
      send_char(8'd66);
      send_char(CHAR_DEL);
   endtask

   // Glyph extremes and control bytes written as glyphs, erase with redraw, newlines.
   task automatic test_glyphs();
      send_char(8'd0);
      send_char(8'd255);
      send_char(8'd1);
      send_char(8'd9);
      send_char(8'd13);
      send_char(8'd128);
      send_char(8'd126);
      send_char(CHAR_BS);          // redraw of the 128
      send_char(CHAR_DEL);
      send_char(CHAR_NEWLINE);
      send_char(CHAR_NEWLINE);     // newline on an empty line still scrolls
   endtask

   // Color register extremes; a redraw must show the colors the cell was written with.
   task automatic test_colors();
      set_colors(4'd15, 4'd0);
      send_char(8'd120);
      send_char(8'd121);
      set_colors(4'd0, 4'd15);
      send_char(CHAR_BS);          // blank in new colors, redraw in old ones
      send_char(8'd122);
      send_char(CHAR_BS);
      send_char(CHAR_NEWLINE);
   endtask

   // Full line: wrap with scroll-then-write, erase from the full position, newline at full.
   task automatic test_full_line();
      idle_pct  = 0;
      stall_pct = 30;
      for (int i = 0; i < COLUMNS; i++) send_char(CHAR_W'(33 + i));
      send_char(8'd200);           // scroll, then column 0
      for (int i = 1; i < COLUMNS; i++) send_char(CHAR_W'(i * 3));
      send_char(CHAR_BS);          // blank the last column, redraw the one before it
      send_char(8'd64);
      send_char(CHAR_NEWLINE);     // newline while full: one scroll only
      for (int i = 0; i < COLUMNS; i++) send_char(CHAR_W'($urandom_range(255)));
      send_char(CHAR_NEWLINE);
   endtask

   // Random text in bursts: long lines that wrap, ordinary typing with edits, raw noise.
   task automatic run_random_phase(input int sender_idle, input int receiver_stall,
                                   input int count);
      int                burst_left;
      int                nl_pct;
      int                erase_pct;
      int                pick;
      logic [CHAR_W-1:0] code;
      burst_left = 0;
      nl_pct     = 0;
      erase_pct  = 0;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(60, 10);
            pick = $urandom_range(99);
            if (pick < 50) begin
               nl_pct = 1;
               erase_pct = 4;
            end else if (pick < 80) begin
               nl_pct = 5;
               erase_pct = 12;
            end else begin
               nl_pct = 15;
               erase_pct = 25;
            end
            // some bursts run flat out whatever the phase asks
            if ($urandom_range(99) < 20) begin
               idle_pct  = 0;
               stall_pct = 0;
            end else begin
               idle_pct  = sender_idle;
               stall_pct = receiver_stall;
            end
         end
         burst_left--;
         pick = $urandom_range(99);
         if (pick < nl_pct) code = CHAR_NEWLINE;
         else if (pick < nl_pct + erase_pct) code = $urandom_range(1) ? CHAR_BS : CHAR_DEL;
         else code = CHAR_W'($urandom_range(255));
         send_char(code);
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------
   initial begin
      cursor_col = 0;
      foreach (line_cells[i]) line_cells[i] = BLANK_CELL;
      fg_reg       = FG_RESET;
      bg_reg       = BG_RESET;
      idle_pct     = 0;
      stall_pct    = 0;
      errors       = 0;
      chars_sent   = 0;
      writes_seen  = 0;
      scrolls_seen = 0;
      cycle_count  = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part runs on the reset colors first
      test_line_start();
      test_glyphs();
      test_colors();
      test_full_line();

      // random part: one phase per idle/stall mix, new colors before each
      set_colors(4'd3, 4'd12);
      run_random_phase(0, 0, 215);
      set_colors(4'd15, 4'd15);
      run_random_phase(62, 0, 215);
      set_colors(4'd0, 4'd0);
      run_random_phase(0, 62, 215);
      set_colors(COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)));
      run_random_phase(16, 16, 215);

      // drain; the cycle limit catches a unit that never delivers
      req_tvalid <= 1'b0;
      while (expected_cell_ops.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_cell_ops.size() != 0) begin
         $error("%0d expected results never arrived", expected_cell_ops.size());
         errors++;
      end

      $display("Run: %0d characters sent, %0d cell writes and %0d scrolls checked,",
               chars_sent, writes_seen, scrolls_seen);
      $display("     under four sender/receiver idle mixes and color registers from 0 to 15.");
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tclw_pkg.sv
rtl/tclw_ram.sv
rtl/tclw_queue.sv
rtl/tclw_front.sv
rtl/tclw_back.sv
rtl/text_console_line_writer_unit.sv
tb/tb_text_console_line_writer_unit.sv
